/* rtl/pbtt_pkg.sv */
// Shared types and codes for the priority bucket task table.
// No dependencies; imported by pbtt_cell, pbtt_ctrl and the top level.
`default_nettype none

package pbtt_pkg;

    localparam logic [2:0] TOP_LEVEL = 3'd5;

    // request types
    localparam logic [1:0] REQ_ADD      = 2'd0;
    localparam logic [1:0] REQ_LIST     = 2'd1;
    localparam logic [1:0] REQ_COMPLETE = 2'd2;

    // result status codes
    localparam logic [2:0] STAT_ADDED   = 3'd0;
    localparam logic [2:0] STAT_ENTRY   = 3'd1;
    localparam logic [2:0] STAT_EMPTY   = 3'd2;
    localparam logic [2:0] STAT_DONE    = 3'd3;
    localparam logic [2:0] STAT_MISSING = 3'd4;
    localparam logic [2:0] STAT_REJECT  = 3'd5;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] task_key;
        logic [2:0]  level;
        logic [2:0]  min_level;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] out_key;
        logic [2:0]  out_level;
        logic [31:0] out_stamp;
        logic        table_full;
        logic        last;
    } rsp_t;

    // per-cell entry fields other than the key
    typedef struct packed {
        logic        valid;
        logic [2:0]  level;
        logic [31:0] stamp;
    } meta_t;

    typedef struct packed {
        logic match;
        logic listed;
        logic ins_pt;
    } cell_flags_t;

    typedef struct packed {
        logic [2:0] min_level;
        logic [2:0] new_level;
    } cmp_ctl_t;

    typedef struct packed {
        logic head_match;
        logic head_listed;
        logic head_ins;
        logic next_listed;
        logic tail_valid;
    } chain_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_LIST,
        ST_FIND,
        ST_DROP,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

/* rtl/priority_bucket_task_table.sv */
// Priority bucket task table, top level.
// Channels: req (valid/stall) carries one request word: add, list or complete.
// rsp (valid/stall) carries result words; every request except type 3 gives
// at least one, and the final word of a request has last set.
// Tasks live in a ring of CAPACITY cells, kept sorted by level (5 first) and
// newest first within a level. Add, list and complete rotate the ring once
// past the head, one cell per cycle while no rsp stall holds a list. A
// complete that finds its task makes a second rotation to remove it (find
// pass, then remove pass); one that misses makes the find pass only. A
// rejected or full add does not rotate the ring.
// One request is in work at a time; req_stall is high until it finishes.
// A result word sits in an output register, so the next request is taken
// while the last word still waits. A stall on rsp freezes a list rotation
// only when it has a word to emit.
// Reset empties the table and clears the stamp counter; no clearing pass.
// Depends on pbtt_pkg, pbtt_cell and pbtt_ctrl.
`default_nettype none

module priority_bucket_task_table #(
    parameter int CAPACITY  = 32,
    parameter int KEY_WIDTH = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  pbtt_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output pbtt_pkg::rsp_t  rsp
);
    import pbtt_pkg::*;

    // link[i] is cell i's content; link[CAPACITY] is the word fed to the tail
    meta_t                link_meta [CAPACITY+1];
    logic [KEY_WIDTH-1:0] link_key  [CAPACITY+1];
    cell_flags_t          cell_flags [CAPACITY];

    logic                 shift;
    cmp_ctl_t             cmp;
    logic [KEY_WIDTH-1:0] cmp_key;
    chain_status_t        status;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        pbtt_cell #(
            .KEY_WIDTH (KEY_WIDTH)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift    (shift),
            .nbr_meta (link_meta[i+1]),
            .nbr_key  (link_key[i+1]),
            .cmp      (cmp),
            .cmp_key  (cmp_key),
            .meta     (link_meta[i]),
            .key      (link_key[i]),
            .flags    (cell_flags[i])
        );
    end

    assign status.head_match  = cell_flags[0].match;
    assign status.head_listed = cell_flags[0].listed;
    assign status.head_ins    = cell_flags[0].ins_pt;
    assign status.next_listed = cell_flags[1].listed;
    assign status.tail_valid  = link_meta[CAPACITY-1].valid;

    pbtt_ctrl #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .head_meta (link_meta[0]),
        .head_key  (link_key[0]),
        .next_meta (link_meta[1]),
        .next_key  (link_key[1]),
        .status    (status),
        .shift     (shift),
        .tail_meta (link_meta[CAPACITY]),
        .tail_key  (link_key[CAPACITY]),
        .cmp       (cmp),
        .cmp_key   (cmp_key)
    );

endmodule

`default_nettype wire

/* rtl/pbtt_cell.sv */
// One entry cell of the task ring: holds key, level, stamp and valid,
// loads from its right neighbor on shift. Depends on pbtt_pkg.
`default_nettype none

module pbtt_cell #(
    parameter int KEY_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   shift,
    input  pbtt_pkg::meta_t        nbr_meta,
    input  logic [KEY_WIDTH-1:0]   nbr_key,
    input  pbtt_pkg::cmp_ctl_t     cmp,
    input  logic [KEY_WIDTH-1:0]   cmp_key,
    output pbtt_pkg::meta_t        meta,
    output logic [KEY_WIDTH-1:0]   key,
    output pbtt_pkg::cell_flags_t  flags
);
    import pbtt_pkg::*;

    logic                 valid_reg;
    logic [2:0]           level_reg;
    logic [31:0]          stamp_reg;
    logic [KEY_WIDTH-1:0] key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= nbr_meta.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            level_reg <= nbr_meta.level;
            stamp_reg <= nbr_meta.stamp;
            key_reg   <= nbr_key;
        end
    end

    assign meta.valid = valid_reg;
    assign meta.level = level_reg;
    assign meta.stamp = stamp_reg;
    assign key        = key_reg;

    assign flags.match  = valid_reg && (key_reg == cmp_key);
    assign flags.listed = valid_reg && (level_reg >= cmp.min_level);
    // new task goes ahead of every entry of its own level or lower
    assign flags.ins_pt = !valid_reg || (level_reg <= cmp.new_level);

endmodule

`default_nettype wire

/* rtl/pbtt_ctrl.sv */
// Sequencer for the task ring: request decode, head-of-ring insert/list/
// search/remove logic, stamp counter and result register. Uses pbtt_pkg.
`default_nettype none

module pbtt_ctrl #(
    parameter int CAPACITY  = 32,
    parameter int KEY_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  pbtt_pkg::req_t           req,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output pbtt_pkg::rsp_t           rsp,
    input  pbtt_pkg::meta_t          head_meta,
    input  logic [KEY_WIDTH-1:0]     head_key,
    input  pbtt_pkg::meta_t          next_meta,
    input  logic [KEY_WIDTH-1:0]     next_key,
    input  pbtt_pkg::chain_status_t  status,
    output logic                     shift,
    output pbtt_pkg::meta_t          tail_meta,
    output logic [KEY_WIDTH-1:0]     tail_key,
    output pbtt_pkg::cmp_ctl_t       cmp,
    output logic [KEY_WIDTH-1:0]     cmp_key
);
    import pbtt_pkg::*;

    localparam int CW = $clog2(CAPACITY);

    function automatic logic [KEY_WIDTH-1:0] fit_key(input logic [31:0] k);
        logic [KEY_WIDTH+31:0] w;
        w = {{KEY_WIDTH{1'b0}}, k};
        return w[KEY_WIDTH-1:0];
    endfunction

    state_t               state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    req_t                 req_reg, req_next;
    meta_t                carry_meta_reg, carry_meta_next;
    logic [KEY_WIDTH-1:0] carry_key_reg, carry_key_next;
    logic                 mark_reg, mark_next;      // inserted / found / dropped
    logic [2:0]           lvl_reg, lvl_next;        // lowest level holding a match
    logic [31:0]          stamp_reg, stamp_next;
    logic [2:0]           pend_stat_reg, pend_stat_next;
    logic                 pend_full_reg, pend_full_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_t                 rsp_reg, rsp_next;

    logic                 accept;
    logic                 last_step;
    logic                 slot_free;
    logic                 need_emit;
    logic                 adv;
    logic                 drop_hit;
    logic                 add_ok;
    logic                 rsp_load;
    logic [KEY_WIDTH+31:0] head_key_wide;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign last_step = (cnt_reg == CW'(CAPACITY - 1));
    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign need_emit = status.head_listed || (cnt_reg == '0);
    assign adv       = !need_emit || slot_free;
    assign drop_hit  = status.head_match && (head_meta.level == lvl_reg);
    assign add_ok    = accept && (req.req_type == REQ_ADD) && (req.level <= TOP_LEVEL)
                       && !status.tail_valid;
    assign head_key_wide = {32'b0, head_key};

    assign cmp.min_level = (req_reg.min_level > TOP_LEVEL) ? 3'd0 : req_reg.min_level;
    assign cmp.new_level = req_reg.level;
    assign cmp_key       = fit_key(req_reg.task_key);

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.req_type)
                        REQ_ADD:
                        begin
                            if ((req.level > TOP_LEVEL) || status.tail_valid)
                                state_next = ST_RESP;
                            else
                                state_next = ST_ADD;
                        end
                        REQ_LIST:     state_next = ST_LIST;
                        REQ_COMPLETE: state_next = ST_FIND;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD:
            begin
                if (last_step)
                    state_next = ST_RESP;
            end
            ST_LIST:
            begin
                if (last_step && adv)
                    state_next = ST_IDLE;
            end
            ST_FIND:
            begin
                if (last_step)
                    state_next = (mark_reg || status.head_match) ? ST_DROP : ST_RESP;
            end
            ST_DROP:
            begin
                if (last_step)
                    state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        shift           = 1'b0;
        tail_meta       = head_meta;
        tail_key        = head_key;
        cnt_next        = cnt_reg;
        req_next        = req_reg;
        carry_meta_next = carry_meta_reg;
        carry_key_next  = carry_key_reg;
        mark_next       = mark_reg;
        lvl_next        = lvl_reg;
        stamp_next      = stamp_reg;
        pend_stat_next  = pend_stat_reg;
        pend_full_next  = pend_full_reg;
        rsp_load        = 1'b0;
        rsp_next        = rsp_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next       = req;
                    cnt_next       = '0;
                    mark_next      = 1'b0;
                    pend_full_next = 1'b0;
                    case (req.req_type)
                        REQ_ADD:
                        begin
                            if (req.level > TOP_LEVEL)
                            begin
                                pend_stat_next = STAT_REJECT;
                            end
                            else if (status.tail_valid)
                            begin
                                pend_stat_next = STAT_REJECT;
                                pend_full_next = 1'b1;
                            end
                            else
                            begin
                                pend_stat_next        = STAT_ADDED;
                                carry_meta_next.valid = 1'b1;
                                carry_meta_next.level = req.level;
                                carry_meta_next.stamp = stamp_reg;
                                carry_key_next        = fit_key(req.task_key);
                                stamp_next            = stamp_reg + 32'd1;
                            end
                        end
                        REQ_COMPLETE: pend_stat_next = STAT_MISSING;
                        default:      pend_stat_next = pend_stat_reg;
                    endcase
                end
            end
            ST_ADD:
            begin
                shift    = 1'b1;
                cnt_next = cnt_reg + CW'(1);
                // from the insertion point on, everything slides one place back
                if (mark_reg || status.head_ins)
                begin
                    tail_meta       = carry_meta_reg;
                    tail_key        = carry_key_reg;
                    carry_meta_next = head_meta;
                    carry_key_next  = head_key;
                    mark_next       = 1'b1;
                end
            end
            ST_LIST:
            begin
                if (adv)
                begin
                    shift    = 1'b1;
                    cnt_next = cnt_reg + CW'(1);
                    if (need_emit)
                    begin
                        rsp_load = 1'b1;
                        if (status.head_listed)
                        begin
                            rsp_next.status     = STAT_ENTRY;
                            rsp_next.out_key    = head_key_wide[31:0];
                            rsp_next.out_level  = head_meta.level;
                            rsp_next.out_stamp  = head_meta.stamp;
                            rsp_next.table_full = 1'b0;
                            rsp_next.last       = last_step || !status.next_listed;
                        end
                        else
                        begin
                            rsp_next        = '0;
                            rsp_next.status = STAT_EMPTY;
                            rsp_next.last   = 1'b1;
                        end
                    end
                end
            end
            ST_FIND:
            begin
                shift    = 1'b1;
                cnt_next = cnt_reg + CW'(1);
                // ring is sorted by level descending: the last match seen is lowest
                if (status.head_match)
                begin
                    mark_next = 1'b1;
                    lvl_next  = head_meta.level;
                end
                if (last_step)
                begin
                    cnt_next  = '0;
                    mark_next = 1'b0;
                    if (mark_reg || status.head_match)
                        pend_stat_next = STAT_DONE;
                end
            end
            ST_DROP:
            begin
                shift    = 1'b1;
                cnt_next = cnt_reg + CW'(1);
                // once the victim reaches the head, feed the tail one word ahead
                if (mark_reg || drop_hit)
                begin
                    mark_next = 1'b1;
                    if (last_step)
                    begin
                        tail_meta = '0;
                        tail_key  = head_key;
                    end
                    else
                    begin
                        tail_meta = next_meta;
                        tail_key  = next_key;
                    end
                end
            end
            ST_RESP:
            begin
                if (slot_free)
                begin
                    rsp_load            = 1'b1;
                    rsp_next            = '0;
                    rsp_next.status     = pend_stat_reg;
                    rsp_next.table_full = pend_full_reg;
                    rsp_next.last       = 1'b1;
                end
            end
            default:
            begin
                shift = 1'b0;
            end
        endcase

        rsp_valid_next = rsp_load || (rsp_valid_reg && rsp_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            mark_reg      <= 1'b0;
            stamp_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            mark_reg      <= mark_next;
            stamp_reg     <= stamp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        carry_meta_reg <= carry_meta_next;
        carry_key_reg  <= carry_key_next;
        lvl_reg        <= lvl_next;
        pend_stat_reg  <= pend_stat_next;
        pend_full_reg  <= pend_full_next;
        if (rsp_load)
            rsp_reg <= rsp_next;
    end

    a_bad_level_resp: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req.req_type == REQ_ADD) && (req.level > TOP_LEVEL)
        |=> state_reg == ST_RESP)
        else $error("bad level add did not go straight to response");

    a_add_pushes_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD) && last_step |=> !carry_meta_reg.valid)
        else $error("insert pass pushed a valid entry off the ring");

    a_drop_happens: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DROP) && last_step |-> mark_reg || drop_hit)
        else $error("remove pass ended without removing the found task");

    a_stamp_only_on_add: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(stamp_reg) |-> $past(add_ok))
        else $error("stamp counter moved without a stored add");

endmodule

`default_nettype wire

/* tb/task_table_checker.sv */
// Result checker for the priority bucket task table: watches req and rsp,
// keeps its own copy of the table and compares every result word in order.
// Depends on pbtt_pkg for the word types and status codes.

module task_table_checker #(
    parameter int CAPACITY = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic            req_stall,
    input  pbtt_pkg::req_t  req,
    input  logic            rsp_valid,
    input  logic            rsp_stall,
    input  pbtt_pkg::rsp_t  rsp,
    output int              mismatches,
    output int              outstanding,
    output int              words_checked,
    output int              full_drops
);
    import pbtt_pkg::*;

    logic [31:0] slot_key   [CAPACITY];
    logic [2:0]  slot_level [CAPACITY];
    logic [31:0] slot_stamp [CAPACITY];
    logic        slot_valid [CAPACITY];
    logic [31:0] stamp_ctr;
    int          by_age     [CAPACITY];

    rsp_t        expected_q [$];

    initial
    begin
        mismatches    = 0;
        outstanding   = 0;
        words_checked = 0;
        full_drops    = 0;
    end

    function automatic rsp_t result_word(input logic [2:0] st, input logic [31:0] key,
                                         input logic [2:0] lv, input logic [31:0] stamp,
                                         input logic full, input logic fin);
        rsp_t w;
        w.status     = st;
        w.out_key    = key;
        w.out_level  = lv;
        w.out_stamp  = stamp;
        w.table_full = full;
        w.last       = fin;
        return w;
    endfunction

    function automatic logic [31:0] age_of(input int s);
        return stamp_ctr - slot_stamp[s];
    endfunction

    // fills by_age with the live slots of one level, newest first,
    // ties to the lower slot; returns how many
    function automatic int gather_level(input logic [2:0] lv);
        int n;
        int j;
        n = 0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (slot_valid[i] && slot_level[i] == lv)
            begin
                j = n;
                while (j > 0 && age_of(by_age[j - 1]) > age_of(i))
                begin
                    by_age[j] = by_age[j - 1];
                    j--;
                end
                by_age[j] = i;
                n++;
            end
        end
        return n;
    endfunction

    task automatic predict_results(input req_t w);
        int   n;
        int   s;
        int   p;
        int   floor_lv;
        bit   hit;
        bit   have_prev;
        rsp_t prev;
        case (w.req_type)
            REQ_ADD:
            begin
                if (w.level > TOP_LEVEL)
                    expected_q.push_back(result_word(STAT_REJECT, '0, '0, '0, 1'b0, 1'b1));
                else
                begin
                    s = -1;
                    for (int i = CAPACITY - 1; i >= 0; i--)
                        if (!slot_valid[i])
                            s = i;
                    if (s < 0)
                    begin
                        full_drops++;
                        expected_q.push_back(result_word(STAT_REJECT, '0, '0, '0, 1'b1, 1'b1));
                    end
                    else
                    begin
                        slot_valid[s] = 1'b1;
                        slot_key[s]   = w.task_key;
                        slot_level[s] = w.level;
                        slot_stamp[s] = stamp_ctr;
                        stamp_ctr     = stamp_ctr + 32'd1;
                        expected_q.push_back(result_word(STAT_ADDED, '0, '0, '0, 1'b0, 1'b1));
                    end
                end
            end
            REQ_LIST:
            begin
                floor_lv  = (w.min_level > TOP_LEVEL) ? 0 : int'(w.min_level);
                have_prev = 1'b0;
                prev      = '0;
                // hold back one word so the final one can get last set
                for (p = int'(TOP_LEVEL); p >= floor_lv; p--)
                begin
                    n = gather_level(3'(p));
                    for (int j = 0; j < n; j++)
                    begin
                        s = by_age[j];
                        if (have_prev)
                            expected_q.push_back(prev);
                        prev = result_word(STAT_ENTRY, slot_key[s], slot_level[s],
                                           slot_stamp[s], 1'b0, 1'b0);
                        have_prev = 1'b1;
                    end
                end
                if (have_prev)
                begin
                    prev.last = 1'b1;
                    expected_q.push_back(prev);
                end
                else
                    expected_q.push_back(result_word(STAT_EMPTY, '0, '0, '0, 1'b0, 1'b1));
            end
            REQ_COMPLETE:
            begin
                hit = 1'b0;
                for (p = 0; p <= int'(TOP_LEVEL); p++)
                begin
                    n = gather_level(3'(p));
                    for (int j = 0; j < n; j++)
                    begin
                        s = by_age[j];
                        if (!hit && slot_key[s] == w.task_key)
                        begin
                            slot_valid[s] = 1'b0;
                            hit = 1'b1;
                        end
                    end
                    if (hit)
                        break;
                end
                expected_q.push_back(result_word(hit ? STAT_DONE : STAT_MISSING,
                                                 '0, '0, '0, 1'b0, 1'b1));
            end
            default:
                ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic compare_word(input rsp_t got);
        rsp_t want;
        if (expected_q.size() == 0)
        begin
            $error("result word with nothing expected: status %0d key %0h",
                   got.status, got.out_key);
            mismatches++;
        end
        else
        begin
            want = expected_q.pop_front();
            words_checked++;
            check_field("status", 32'(want.status), 32'(got.status));
            check_field("out_key", want.out_key, got.out_key);
            check_field("out_level", 32'(want.out_level), 32'(got.out_level));
            check_field("out_stamp", want.out_stamp, got.out_stamp);
            check_field("table_full", 32'(want.table_full), 32'(got.table_full));
            check_field("last", 32'(want.last), 32'(got.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
                slot_valid[i] = 1'b0;
            stamp_ctr = '0;
            expected_q.delete();
            outstanding = 0;
        end
        else
        begin
            // a word leaving now belongs to an earlier request
            if (rsp_valid && !rsp_stall)
                compare_word(rsp);
            if (req_valid && !req_stall)
                predict_results(req);
            outstanding = expected_q.size();
        end
    end

endmodule

/* tb/tb.sv */
// Testbench top for priority_bucket_task_table: clock, reset, request
// stimulus, output stall pattern and the final verdict.
// Depends on pbtt_pkg, the block and task_table_checker.

module tb;
    import pbtt_pkg::*;

    localparam int         CAPACITY      = 32;
    localparam logic [1:0] REQ_UNUSED    = 2'd3;
    localparam int         SETTLE_CYCLES = 2 * CAPACITY + 8;
    localparam int         LONG_HOLD     = 150;
    localparam int         PHASE_WORDS   = 134;
    localparam int         SEGMENT       = 40;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    int mismatches;
    int outstanding;
    int words_checked;
    int full_drops;

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int hold_asks     = 0;
    int hold_served   = 0;
    int sent_by_type [4];

    logic [31:0] key_pool [16];

    priority_bucket_task_table #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (32)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    task_table_checker #(
        .CAPACITY (CAPACITY)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req           (req),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp           (rsp),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .words_checked (words_checked),
        .full_drops    (full_drops)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // output side: random stall, with one long hold when asked
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_asks != hold_served)
            begin
                hold_served = hold_asks;
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
            end
            rsp_stall <= ($urandom_range(99) < sink_idle_pct);
        end
    end

    function automatic req_t req_word(input logic [1:0] kind, input logic [31:0] key,
                                      input logic [2:0] lv, input logic [2:0] minl);
        req_t w;
        w.req_type  = kind;
        w.task_key  = key;
        w.level     = lv;
        w.min_level = minl;
        return w;
    endfunction

    function automatic req_t random_req(input mix_t mix);
        req_t w;
        int   roll;
        w.task_key  = $urandom;
        w.level     = 3'($urandom_range(7));
        w.min_level = 3'($urandom_range(7));
        roll        = $urandom_range(99);
        if (roll < 3)
            w.req_type = REQ_UNUSED;
        else
        begin
            case (mix)
                MIX_FILL:  w.req_type = (roll < 88) ? REQ_ADD : (roll < 95) ? REQ_LIST
                                                                           : REQ_COMPLETE;
                MIX_DRAIN: w.req_type = (roll < 28) ? REQ_ADD : (roll < 40) ? REQ_LIST
                                                                           : REQ_COMPLETE;
                default:   w.req_type = (roll < 50) ? REQ_ADD : (roll < 70) ? REQ_LIST
                                                                           : REQ_COMPLETE;
            endcase
        end
        // small key pool so completes usually hit and duplicates occur
        if (w.req_type == REQ_ADD)
        begin
            if ($urandom_range(99) < 88)
                w.level = 3'($urandom_range(5));
            if ($urandom_range(99) < 80)
                w.task_key = key_pool[$urandom_range(15)];
        end
        else if (w.req_type == REQ_COMPLETE && $urandom_range(99) < 85)
            w.task_key = key_pool[$urandom_range(15)];
        return w;
    endfunction

    // entered and left at a falling edge; valid stays up between back-to-back words
    task automatic send_word(input req_t w);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        do
            @(posedge clk);
        while (req_stall);
        sent_by_type[w.req_type]++;
        @(negedge clk);
    endtask

    task automatic pause_until_drained();
        req_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        req_t w;
        int   counted;
        for (int i = 0; i < 16; i++)
            key_pool[i] = $urandom;
        for (int i = 0; i < 4; i++)
            sent_by_type[i] = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        src_idle_pct  = 20;
        sink_idle_pct = 52;

        // directed: empty table, rejects, extremes, ordering, duplicates
        send_word(req_word(REQ_LIST, 32'h0, 3'd0, 3'd0));
        send_word(req_word(REQ_COMPLETE, 32'h0, 3'd0, 3'd0));
        send_word(req_word(REQ_ADD, 32'h0, 3'd6, 3'd7));
        send_word(req_word(REQ_ADD, 32'hFFFF_FFFF, 3'd7, 3'd0));
        send_word(req_word(REQ_ADD, 32'h0, 3'd0, 3'd0));
        send_word(req_word(REQ_ADD, 32'hFFFF_FFFF, 3'd5, 3'd7));
        send_word(req_word(REQ_ADD, 32'hA5A5_A5A5, 3'd3, 3'd0));
        send_word(req_word(REQ_ADD, 32'hA5A5_A5A5, 3'd3, 3'd0));
        send_word(req_word(REQ_ADD, 32'h5A5A_5A5A, 3'd1, 3'd0));
        send_word(req_word(REQ_ADD, 32'h1234_5678, 3'd2, 3'd0));
        send_word(req_word(REQ_ADD, 32'h0F0F_00FF, 3'd4, 3'd0));
        send_word(req_word(REQ_ADD, 32'hA5A5_A5A5, 3'd0, 3'd0));
        send_word(req_word(REQ_LIST, 32'hFFFF_FFFF, 3'd7, 3'd7));
        send_word(req_word(REQ_LIST, 32'h0, 3'd0, 3'd5));
        send_word(req_word(REQ_LIST, 32'h0, 3'd0, 3'd3));
        // duplicate key: lowest level first, so the level 0 copy goes
        send_word(req_word(REQ_COMPLETE, 32'hA5A5_A5A5, 3'd7, 3'd7));
        send_word(req_word(REQ_COMPLETE, 32'hA5A5_A5A5, 3'd0, 3'd0));
        send_word(req_word(REQ_COMPLETE, 32'h7777_7777, 3'd0, 3'd0));
        send_word(req_word(REQ_UNUSED, 32'hFFFF_FFFF, 3'd7, 3'd7));
        send_word(req_word(REQ_LIST, 32'h0, 3'd0, 3'd6));
        send_word(req_word(REQ_COMPLETE, 32'hFFFF_FFFF, 3'd0, 3'd0));
        send_word(req_word(REQ_LIST, 32'h0, 3'd0, 3'd0));
        pause_until_drained();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct  = 20;
                    sink_idle_pct = 52;
                    hold_asks++;    // long output hold while requests keep coming
                end
                1:
                begin
                    src_idle_pct  = 52;
                    sink_idle_pct = 20;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            counted = 0;
            while (counted < PHASE_WORDS)
            begin
                w = random_req(mix_t'((counted / SEGMENT) % 3));
                send_word(w);
                if (w.req_type != REQ_UNUSED)
                    counted++;
            end
            pause_until_drained();
        end

        $display("Run covered %0d adds, %0d lists, %0d completes, %0d unused-type words.",
                 sent_by_type[REQ_ADD], sent_by_type[REQ_LIST],
                 sent_by_type[REQ_COMPLETE], sent_by_type[REQ_UNUSED]);
        $display("%0d result words checked, %0d adds dropped on a full table.",
                 words_checked, full_drops);
        if (mismatches == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
